// ----- hw/rtl/iala_pkg.sv -----
package iala_pkg;

    localparam int CAPACITY_DEF   = 8;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 3;
    localparam int COUNT_W = 4;

    localparam int IN_FIELDS_W  = FUNC_W + INDEX_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + 1 + POS_W + VALUE_W + COUNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_FIND   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic               go;
        logic               ins_ok;
        logic               del_ok;
        logic [INDEX_W-1:0] index;
    } t_cell_cmd;

endpackage

// ----- hw/rtl/iala_cell.sv -----
module iala_cell
    import iala_pkg::*;
#(
    parameter int POS        = 0,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int CNT_W      = 4
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [WORD_WIDTH-1:0] i_word,
    input  logic [WORD_WIDTH-1:0] i_left,
    input  logic [WORD_WIDTH-1:0] i_right,
    output logic [WORD_WIDTH-1:0] o_word,
    output logic                  o_match
);

    localparam logic [31:0] POS_U = 32'(POS);

    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] n_word;
    logic                  r_match;
    logic                  n_match;
    logic [31:0]           w_idx;

    assign w_idx = 32'(i_cmd.index);

    always_comb begin
        n_word  = r_word;
        n_match = r_match;
        if (i_cmd.go) begin
            // compare against the list as it stood before this transaction
            n_match = (r_word == i_word) && (32'(i_count) > POS_U);
            if (i_cmd.ins_ok) begin
                if (w_idx < POS_U) begin
                    n_word = i_left;
                end else if (w_idx == POS_U) begin
                    n_word = i_word;
                end
            end else if (i_cmd.del_ok) begin
                if (w_idx <= POS_U) begin
                    n_word = i_right;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_match <= n_match;
    end

    assign o_word  = r_word;
    assign o_match = r_match;

endmodule

// ----- hw/rtl/indexed_array_list_core.sv -----
// Ordered list of up to CAPACITY words, kept in a chain of cells.
// Input stream (s_axis): one transaction per operation. tdata carries func,
// index and value; func selects insert, delete, find or clear.
// Output stream (m_axis): exactly one result transaction per input, in order,
// carrying ok, found, position, removed_value, count and empty_res.
// Insert and delete move every cell at once: each cell keeps its word or loads
// the new word, its lower or upper neighbor's in the cycle the input is accepted.
// Find compares all cells in that same cycle and registers one match bit per
// cell; the lowest matching position is picked when the operation moves from
// the operation stage into the output register, which holds the result.
// Throughput: one operation per cycle while the output is taken; the limit is
// the parallel shift of the cell chain.
// A result waits in the output register while the receiver stalls; one more
// operation can be accepted behind it, then tready drops until it is taken.
// Reset empties the list and drops both pipeline stages; entry words are not
// cleared, since only positions below the count are ever read.
module indexed_array_list_core
    import iala_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [1:0] func, [5:2] index, [37:6] value, rest zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [0] ok, [1] found, [4:2] position, [36:5] removed_value, [40:37] count,
    // [41] empty_res, rest zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SEL_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    t_func                 w_func;
    logic [INDEX_W-1:0]    w_index;
    logic [VALUE_W-1:0]    w_value;
    logic [WORD_WIDTH-1:0] w_word;
    logic [CMP_W-1:0]      w_idx_c;
    logic [CMP_W-1:0]      w_cnt_c;
    logic                  w_s_acc;
    logic                  w_adv;
    logic                  w_ins_ok;
    logic                  w_del_ok;
    t_cell_cmd             w_cmd;

    logic [WORD_WIDTH-1:0] w_cell_word [CAPACITY];
    logic [CAPACITY-1:0]   w_match;
    logic                  w_hit;
    logic [SEL_W-1:0]      w_hit_pos;

    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_a_valid, n_a_valid;
    logic                  r_a_ok, n_a_ok;
    logic                  r_a_find, n_a_find;
    logic [WORD_WIDTH-1:0] r_a_removed, n_a_removed;

    logic                  r_o_valid, n_o_valid;
    logic                  r_o_ok, n_o_ok;
    logic                  r_o_found, n_o_found;
    logic [POS_W-1:0]      r_o_pos, n_o_pos;
    logic [VALUE_W-1:0]    r_o_removed, n_o_removed;
    logic [COUNT_W-1:0]    r_o_count, n_o_count;
    logic                  r_o_empty, n_o_empty;

    assign w_func  = t_func'(i_s_axis_tdata[FUNC_W-1:0]);
    assign w_index = i_s_axis_tdata[FUNC_W +: INDEX_W];
    assign w_value = i_s_axis_tdata[FUNC_W+INDEX_W +: VALUE_W];
    assign w_word  = WORD_WIDTH'(w_value);

    assign w_adv           = r_a_valid && (!r_o_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_a_valid || w_adv;
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    assign w_idx_c  = CMP_W'(w_index);
    assign w_cnt_c  = CMP_W'(r_count);
    assign w_ins_ok = (w_func == FUNC_INSERT) && (r_count != CNT_W'(CAPACITY))
                      && (w_idx_c <= w_cnt_c);
    assign w_del_ok = (w_func == FUNC_DELETE) && (w_idx_c < w_cnt_c);

    assign w_cmd.go     = w_s_acc;
    assign w_cmd.ins_ok = w_ins_ok;
    assign w_cmd.del_ok = w_del_ok;
    assign w_cmd.index  = w_index;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_left;
        logic [WORD_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cell_word[g];
        end else begin : g_mid_l
            assign w_left = w_cell_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_word[g];
        end else begin : g_mid_r
            assign w_right = w_cell_word[g+1];
        end

        iala_cell #(
            .POS        (g),
            .WORD_WIDTH (WORD_WIDTH),
            .CNT_W      (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_count (r_count),
            .i_word  (w_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_cell_word[g]),
            .o_match (w_match[g])
        );
    end

    // lowest matching cell wins
    always_comb begin
        w_hit     = 1'b0;
        w_hit_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit     = 1'b1;
                w_hit_pos = SEL_W'(i);
            end
        end
    end

    always_comb begin
        n_count     = r_count;
        n_a_valid   = r_a_valid;
        n_a_ok      = r_a_ok;
        n_a_find    = r_a_find;
        n_a_removed = r_a_removed;
        if (w_adv) begin
            n_a_valid = 1'b0;
        end
        if (w_s_acc) begin
            n_a_valid   = 1'b1;
            n_a_find    = (w_func == FUNC_FIND);
            n_a_ok      = w_ins_ok || w_del_ok || (w_func == FUNC_CLEAR);
            n_a_removed = w_del_ok ? w_cell_word[SEL_W'(w_index)] : '0;
            priority if (w_func == FUNC_CLEAR) begin
                n_count = '0;
            end else if (w_ins_ok) begin
                n_count = r_count + 1'b1;
            end else if (w_del_ok) begin
                n_count = r_count - 1'b1;
            end else begin
                n_count = r_count;
            end
        end
    end

    always_comb begin
        n_o_valid   = r_o_valid;
        n_o_ok      = r_o_ok;
        n_o_found   = r_o_found;
        n_o_pos     = r_o_pos;
        n_o_removed = r_o_removed;
        n_o_count   = r_o_count;
        n_o_empty   = r_o_empty;
        if (r_o_valid && i_m_axis_tready) begin
            n_o_valid = 1'b0;
        end
        if (w_adv) begin
            n_o_valid   = 1'b1;
            n_o_ok      = r_a_find ? w_hit : r_a_ok;
            n_o_found   = r_a_find && w_hit;
            n_o_pos     = (r_a_find && w_hit) ? POS_W'(w_hit_pos) : '0;
            n_o_removed = VALUE_W'(r_a_removed);
            // count already reflects this transaction
            n_o_count   = COUNT_W'(r_count);
            n_o_empty   = (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_a_valid <= n_a_valid;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_ok      <= n_a_ok;
        r_a_find    <= n_a_find;
        r_a_removed <= n_a_removed;
        r_o_ok      <= n_o_ok;
        r_o_found   <= n_o_found;
        r_o_pos     <= n_o_pos;
        r_o_removed <= n_o_removed;
        r_o_count   <= n_o_count;
        r_o_empty   <= n_o_empty;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_o_empty, r_o_count, r_o_removed,
                                           r_o_pos, r_o_found, r_o_ok});

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && (w_func == FUNC_CLEAR) |=> r_count == '0)
        else $error("clear did not empty the list");

    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && w_ins_ok |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("insert did not grow the count by one");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_found |-> r_o_ok)
        else $error("found result without ok");

    a_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_adv |=> r_a_valid)
        else $error("pending operation dropped");
`endif

endmodule

// ----- tb/sv/list_checker.sv -----
module list_checker
    import iala_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    // [1:0] func, [5:2] index, [37:6] value, rest zero
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    // [0] ok, [1] found, [4:2] position, [36:5] removed_value, [40:37] count,
    // [41] empty_res, rest zero
    input  logic [OUT_TDATA_W-1:0] i_out_data,
    output int                     o_error_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int LIST_DEPTH = CAPACITY_DEF;

    typedef struct packed {
        logic               ok;
        logic               found;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] removed;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_list_result;

    logic [VALUE_W-1:0] list_words [LIST_DEPTH];
    logic [COUNT_W-1:0] list_len = '0;
    t_list_result       pending_results [$];

    initial begin
        o_error_count = 0;
        o_pending     = 0;
        o_checked     = 0;
    end

    // Apply one operation to the shadow list and return the result it yields.
    function automatic t_list_result list_apply(input t_func op,
                                                input logic [INDEX_W-1:0] idx,
                                                input logic [VALUE_W-1:0] word);
        t_list_result res;
        res = '0;
        case (op)
            FUNC_INSERT: begin
                if (list_len < LIST_DEPTH && idx <= list_len) begin
                    for (int i = LIST_DEPTH - 1; i > 0; i--) begin
                        if (i > idx && i <= list_len) list_words[i] = list_words[i-1];
                    end
                    list_words[idx[POS_W-1:0]] = word;
                    list_len = list_len + 1'b1;
                    res.ok = 1'b1;
                end
            end
            FUNC_DELETE: begin
                if (idx < list_len) begin
                    res.removed = list_words[idx[POS_W-1:0]];
                    for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                        if (i >= idx && i + 1 < list_len) list_words[i] = list_words[i+1];
                    end
                    list_len = list_len - 1'b1;
                    res.ok = 1'b1;
                end
            end
            FUNC_FIND: begin
                // lowest matching position wins
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    if (!res.found && i < list_len && list_words[i] == word) begin
                        res.found    = 1'b1;
                        res.position = i[POS_W-1:0];
                    end
                end
                res.ok = res.found;
            end
            default: begin
                list_len = '0;
                res.ok   = 1'b1;
            end
        endcase
        res.count = list_len;
        res.empty = (list_len == 0);
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t list_checker: %s mismatch, expected %0h, actual %0h",
                     $time, what, want, got);
            o_error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            pending_results.delete();
            list_len = '0;
        end else begin
            // results are registered after their inputs are accepted, so compare first
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t list_checker: result %0h with nothing expected",
                             $time, i_out_data);
                    o_error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("ok", want.ok, i_out_data[0]);
                    check_field("found", want.found, i_out_data[1]);
                    check_field("position", want.position, i_out_data[4:2]);
                    check_field("removed_value", want.removed, i_out_data[36:5]);
                    check_field("count", want.count, i_out_data[40:37]);
                    check_field("empty_res", want.empty, i_out_data[41]);
                    check_field("padding", '0,
                                i_out_data[OUT_TDATA_W-1:OUT_FIELDS_W]);
                    o_checked++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(list_apply(t_func'(i_in_data[1:0]),
                                                     i_in_data[5:2],
                                                     i_in_data[37:6]));
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import iala_pkg::*;

    localparam int RANDOM_OPS     = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   in_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  in_data  = '0;
    logic                   in_ready;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] out_data;

    int   error_count;
    int   pending;
    int   checked;
    int   ops_sent    = 0;
    int   idle_cycles = 0;
    logic no_idle     = 1'b0;

    logic [VALUE_W-1:0] recent_words [16];
    int                 recent_wr = 0;

    always #5 clk = ~clk;

    indexed_array_list_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    list_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_error_count (error_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_op(input t_func op, input logic [INDEX_W-1:0] idx,
                            input logic [VALUE_W-1:0] word);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, word, idx, op};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ops_sent++;
    endtask

    // mode 0 fills the list, mode 1 drains it, mode 2 mixes
    task automatic random_op(input int mode);
        int                 roll;
        t_func              op;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] word;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       op = roll < 70 ? FUNC_INSERT : roll < 85 ? FUNC_DELETE :
                          roll < 97 ? FUNC_FIND : FUNC_CLEAR;
            1:       op = roll < 20 ? FUNC_INSERT : roll < 80 ? FUNC_DELETE :
                          roll < 97 ? FUNC_FIND : FUNC_CLEAR;
            default: op = roll < 40 ? FUNC_INSERT : roll < 70 ? FUNC_DELETE :
                          roll < 95 ? FUNC_FIND : FUNC_CLEAR;
        endcase
        idx  = INDEX_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 8));
        roll = $urandom_range(0, 99);
        if (roll < 45)      word = recent_words[4'($urandom_range(0, 15))];
        else if (roll < 65) word = $urandom_range(0, 7);
        else if (roll < 75) word = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        else                word = $urandom();
        if (op == FUNC_INSERT) begin
            recent_words[recent_wr] = word;
            recent_wr = (recent_wr + 1) % 16;
        end
        issue_op(op, idx, word);
    endtask

    // receiver: ready runs broken by stalls
    initial begin
        int run;
        int gap;
        while (!rst_n) @(posedge clk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
            gap = pick_gap();
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        int directed_ops;
        int phase_len;
        int mode;
        foreach (recent_words[i]) recent_words[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: miss, bad delete, insert past the count
        issue_op(FUNC_FIND,   4'd0, 32'h0000_0000);
        issue_op(FUNC_DELETE, 4'd0, 32'h0000_0000);
        issue_op(FUNC_INSERT, 4'd1, 32'h0000_0001);
        // fill with extremes at front, middle and end
        issue_op(FUNC_INSERT, 4'd0, 32'h8000_0000);
        issue_op(FUNC_INSERT, 4'd1, 32'h7fff_ffff);
        issue_op(FUNC_INSERT, 4'd0, 32'h0000_0000);
        issue_op(FUNC_INSERT, 4'd1, 32'hffff_ffff);
        issue_op(FUNC_INSERT, 4'd4, 32'h7fff_ffff);
        issue_op(FUNC_INSERT, 4'd2, 32'h0000_0005);
        issue_op(FUNC_INSERT, 4'd6, 32'ha5a5_a5a5);
        issue_op(FUNC_INSERT, 4'd7, 32'h5a5a_5a5a);
        // full list
        issue_op(FUNC_INSERT, 4'd3, 32'h0000_0001);
        issue_op(FUNC_INSERT, 4'd8, 32'h0000_0001);
        // duplicate resolves to the lowest slot, last slot, miss
        issue_op(FUNC_FIND,   4'd0, 32'h7fff_ffff);
        issue_op(FUNC_FIND,   4'd0, 32'h5a5a_5a5a);
        issue_op(FUNC_FIND,   4'd0, 32'd12345);
        issue_op(FUNC_DELETE, 4'd8, 32'h0000_0000);
        issue_op(FUNC_DELETE, 4'd7, 32'h0000_0000);
        issue_op(FUNC_DELETE, 4'd0, 32'h0000_0000);
        issue_op(FUNC_DELETE, 4'd3, 32'h0000_0000);
        issue_op(FUNC_FIND,   4'd0, 32'h8000_0000);
        issue_op(FUNC_CLEAR,  4'd5, 32'hdead_beef);
        // stale words must not match after clear
        issue_op(FUNC_FIND,   4'd0, 32'h0000_0000);
        issue_op(FUNC_DELETE, 4'd0, 32'h0000_0000);
        issue_op(FUNC_INSERT, 4'd0, 32'd42);
        directed_ops = ops_sent;

        while (ops_sent < directed_ops + RANDOM_OPS) begin
            phase_len = $urandom_range(30, 120);
            mode      = $urandom_range(0, 2);
            no_idle   = ($urandom_range(0, 3) == 0);
            repeat (phase_len) random_op(mode);
        end
        in_valid <= 1'b0;
        no_idle  = 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d list operations sent, %0d results compared", ops_sent, checked);
        $display("summary: insert, delete, find and clear on empty, partial and full lists");
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
